>>> design/des_pkg.sv
// DES package: permutation tables, S-box lookup and round function.
// Used by the key cell, round cell and top-level DES modules; no dependencies.
`default_nettype none
package des_pkg;

  localparam int BlkW = 64;
  localparam int RkW  = 48;

  // Permutation tables, 1-based from the MSB of the source word
  localparam logic [7:0] IP_T [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] FP_T [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] E_T [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] P_T [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
  localparam logic [7:0] PC1_T [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] PC2_T [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [15:0] SHIFT1_T = 16'b1000_0001_0000_0011; // bit r: rotate by one

  localparam logic [3:0] SBOX_T [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  // Control from sequencer to the round cell
  typedef struct packed {
    logic load;     // take a fresh block
    logic advance;  // do one round
  } round_ctl_t;

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_T[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_T[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_T[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_T[i])];
    return r;
  endfunction

  // Feistel function: expand, key mix, S-boxes, P
  function automatic logic [31:0] feistel(input logic [31:0] rt, input logic [47:0] rk);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = rt[32-int'(E_T[i])];
    x = x ^ rk;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX_T[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(P_T[i])];
    return p;
  endfunction

endpackage
`default_nettype wire

>>> design/des_key_cell.sv
// Key schedule cell: holds one 48-bit round key and hands it to its neighbor.
// Depends on des_pkg.
`default_nettype none
module des_key_cell
  import des_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic [47:0]   load_key,
  input  wire logic          shift,
  input  wire logic [47:0]   nbr_key,
  output logic [47:0]        key_r
);

  logic [47:0] key_nxt;

  // Load, rotate from neighbor, or hold
  always_comb begin
    key_nxt = key_r;
    if (load) begin
      key_nxt = load_key;
    end else if (shift) begin
      key_nxt = nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

>>> design/des_round_cell.sv
// Round cell: holds the L/R halves and applies one Feistel round per cycle while advance is set.
// Depends on des_pkg.
`default_nettype none
module des_round_cell
  import des_pkg::*;
(
  input  wire logic          clk,
  input  wire round_ctl_t    ctl,
  input  wire logic [63:0]   blk_in,
  input  wire logic [47:0]   rkey,
  output logic [63:0]        blk_out
);

  logic [31:0] l_r, r_r, l_nxt, r_nxt;
  logic [63:0] ip;

  assign ip = perm_ip(blk_in);

  // Load permuted block or run one round
  always_comb begin
    l_nxt = l_r;
    r_nxt = r_r;
    if (ctl.load) begin
      l_nxt = ip[63:32];
      r_nxt = ip[31:0];
    end else if (ctl.advance) begin
      l_nxt = r_r;
      r_nxt = l_r ^ feistel(r_r, rkey);
    end
  end

  always_ff @(posedge clk) begin
    l_r <= l_nxt;
    r_r <= r_nxt;
  end

  // Final swap and inverse IP
  assign blk_out = perm_fp({r_r, l_r});

endmodule
`default_nettype wire

>>> design/des_block_cipher_unit.sv
// DES block cipher top level: key schedule ring, round cell and sequencer.
// Depends on des_pkg, des_key_cell, des_round_cell.
`default_nettype none
// A result is valid once its block has run all rounds (sixteen rounds through
// the single round cell, one per cycle); the next block is accepted at the
// earliest in the cycle after the result is taken. A key write builds the round
// keys (the write edge loads the key, then the schedule walks through a ring of
// sixteen key cells, one round key a cycle); in_tready stays low until the build
// is done.
// The ring rotates one cell per round during a block (forward for encrypt,
// backward for decrypt). Write the key only while idle.
// Without a loaded key a block returns zero with key_missing set.
module des_block_cipher_unit
  import des_pkg::*;
#(
  parameter int ROUND_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // data_block
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // result_block
  output logic             out_tuser   // key_missing
);

  localparam int CntW = $clog2(ROUND_COUNT + 1);

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic op_r, op_nxt, miss_r, miss_nxt;
  logic key_loaded_r, key_loaded_nxt;
  logic [CntW-1:0] kcnt_r, kcnt_nxt;   // schedule build counter
  logic [55:0] cd_r, cd_nxt;
  logic [47:0] ring [ROUND_COUNT];
  logic        ring_fill, ring_fwd, ring_bwd;
  round_ctl_t  ctl;
  logic [63:0] blk_out;
  logic [27:0] c_rot, d_rot;

  // Key schedule: rotate C/D, shift new round key into ring tail
  always_comb begin
    c_rot = cd_r[55:28];
    d_rot = cd_r[27:0];
    if (SHIFT1_T[kcnt_r[3:0]]) begin
      c_rot = {c_rot[26:0], c_rot[27]};
      d_rot = {d_rot[26:0], d_rot[27]};
    end else begin
      c_rot = {c_rot[25:0], c_rot[27:26]};
      d_rot = {d_rot[25:0], d_rot[27:26]};
    end
  end

  always_comb begin
    kcnt_nxt = kcnt_r;
    cd_nxt = cd_r;
    key_loaded_nxt = key_loaded_r;
    ring_fill = 1'b0;
    if (cfg_we) begin
      cd_nxt = perm_pc1(cfg_wdata);
      kcnt_nxt = '0;
      key_loaded_nxt = 1'b0;
    end else if (kcnt_r < CntW'(ROUND_COUNT)) begin
      cd_nxt = {c_rot, d_rot};
      ring_fill = 1'b1;
      kcnt_nxt = kcnt_r + 1'b1;
      if (kcnt_r == CntW'(ROUND_COUNT - 1)) key_loaded_nxt = 1'b1;
    end
  end

  // Ring of key cells; ring[0] feeds the round cell
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_key
    logic [47:0] nbr;
    always_comb begin
      if (ring_fill) begin
        nbr = (g == ROUND_COUNT - 1) ? perm_pc2(cd_nxt) : ring[(g + 1) % ROUND_COUNT];
      end else if (ring_bwd) begin
        nbr = ring[(g + ROUND_COUNT - 1) % ROUND_COUNT];
      end else begin
        nbr = ring[(g + 1) % ROUND_COUNT];
      end
    end
    des_key_cell u_cell (
      .clk(clk), .load(1'b0), .load_key(48'h0),
      .shift(ring_fill | ring_fwd | ring_bwd), .nbr_key(nbr), .key_r(ring[g])
    );
  end

  // Sequencer register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_loaded_r <= 1'b0;
      kcnt_r <= CntW'(ROUND_COUNT);
    end else begin
      state_r <= state_nxt;
      key_loaded_r <= key_loaded_nxt;
      kcnt_r <= kcnt_nxt;
    end
    cnt_r <= cnt_nxt;
    op_r <= op_nxt;
    miss_r <= miss_nxt;
    cd_r <= cd_nxt;
  end

  // Next state: decrypt pre-rotates ring back one so key 15 sits at the head
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    op_nxt = op_r;
    miss_nxt = miss_r;
    ctl = '0;
    ring_fwd = 1'b0;
    ring_bwd = 1'b0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // hold off input while the key schedule is being built
        in_tready = (kcnt_r == CntW'(ROUND_COUNT));
        if (in_tvalid && in_tready) begin
          ctl.load = 1'b1;
          op_nxt = in_tuser;
          miss_nxt = ~key_loaded_r;
          cnt_nxt = '0;
          if (in_tuser && key_loaded_r) ring_bwd = 1'b1;
          state_nxt = key_loaded_r ? ST_RUN : ST_OUT;
        end
      end
      ST_RUN: begin
        ctl.advance = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        // rotate toward next key; decrypt skips the last step so it ends at home
        if (cnt_r != CntW'(ROUND_COUNT - 1)) begin
          ring_fwd = ~op_r;
          ring_bwd = op_r;
        end else begin
          ring_fwd = ~op_r;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  des_round_cell u_round (
    .clk(clk), .ctl(ctl), .blk_in(in_tdata), .rkey(ring[0]), .blk_out(blk_out)
  );

  assign out_tdata = miss_r ? 64'h0 : blk_out;
  assign out_tuser = miss_r;

endmodule
`default_nettype wire

>>> design/des_block_cipher_unit_chk.sv
// Port-level checker for the DES unit, bound to the top level.
// Depends on des_block_cipher_unit.
`default_nettype none
module des_block_cipher_unit_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tuser
);

  // One block at a time: no input while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");

  // Error result is zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata == 64'h0) else $error("error data nonzero");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");

  // Accepted input drops in_tready the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("accepted twice");

endmodule

bind des_block_cipher_unit des_block_cipher_unit_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
